// ===== sv/json_string_unescaper_macros.svh =====
// assertion macros for the json string unescaper
`ifndef JSON_STRING_UNESCAPER_MACROS_SVH
`define JSON_STRING_UNESCAPER_MACROS_SVH

// same-cycle implication, checked outside reset
`define JSU_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define JSU_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/jsu_pkg.sv =====
// shared types and constants for the json string unescaper
package jsu_pkg;

  // parser modes
  typedef enum logic [1:0] {
    MODE_SEEK,
    MODE_STR,
    MODE_ESC,
    MODE_HEX
  } mode_t;

  // result kinds
  typedef enum logic [2:0] {
    OC_BYTE,
    OC_CLOSED,
    OC_EXPECTED,
    OC_BAD_ESC,
    OC_UNTERM_ESC,
    OC_TRUNC_UNI,
    OC_UNTERM_STR
  } outcome_t;

  // one result item
  typedef struct packed {
    logic [7:0] data;
    outcome_t   outcome;
    logic       last;
  } result_t;

  // result queue geometry
  localparam int QDepth = 8;
  localparam int PtrW   = $clog2(QDepth);
  localparam int CntW   = PtrW + 1;

  // hex decoding
  localparam int       HexDigitW = 4;
  localparam int       AccumW    = 7;
  localparam logic [2:0] HexLastIdx = 3'd3;

  // characters
  localparam logic [7:0] ChQuote  = 8'h22;
  localparam logic [7:0] ChBslash = 8'h5c;
  localparam logic [7:0] ChSpace  = 8'h20;
  localparam logic [7:0] ChTab    = 8'h09;
  localparam logic [7:0] ChCr     = 8'h0d;
  localparam logic [7:0] ChLf     = 8'h0a;
  localparam logic [7:0] ChN      = 8'h6e;
  localparam logic [7:0] ChR      = 8'h72;
  localparam logic [7:0] ChT      = 8'h74;
  localparam logic [7:0] ChU      = 8'h75;

endpackage

// ===== sv/json_string_unescaper.sv =====
// Decodes a JSON string literal from a byte stream into its unescaped bytes.
//
// Input channel in_*: one raw JSON byte per item in in_tdata, in_tlast marks
// the last byte of the available text. Result channel out_*: one result item
// per handshake, out_tdata the decoded byte, out_tuser the outcome code
// (0 byte, 1 closed, 2 expected string, 3 bad escape, 4 unterminated escape,
// 5 truncated unicode, 6 unterminated string), out_tlast on the last result
// that one input byte caused.
//
// Each accepted byte is registered in an input stage, decoded combinationally
// and its zero, one or two results are pushed into an 8-entry result queue
// that drives the output. One byte is accepted every cycle while the queue
// has room for two more results beyond those of the byte in flight. When the
// receiver stalls, bytes keep being taken until the queue lacks that room.
//
// Synchronous reset empties the queue, drops the byte in flight and puts the
// parser back to seeking an opening quote with the hex state cleared.
module json_string_unescaper
  import jsu_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] in_byte
  input  logic       in_tlast,   // final_byte
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [7:0] out_byte
  output logic [2:0] out_tuser,  // [2:0] outcome
  output logic       out_tlast   // run_last
);

  `include "json_string_unescaper_macros.svh"

  // input stage
  logic       stg_v_r;
  logic [7:0] stg_byte_r;
  logic       stg_fin_r;

  // parser state
  mode_t             mode_r, mode_nxt;
  logic [2:0]        hex_count_r, hex_count_nxt;
  logic [AccumW-1:0] hex_accum_r, hex_accum_nxt;
  logic              hex_stopped_r, hex_stopped_nxt;

  // result queue
  result_t         queue_r [QDepth];
  logic [PtrW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CntW-1:0] fill_r, fill_nxt;

  // decode outputs
  result_t    res0, res1;
  logic [1:0] push_n;

  logic       in_acc, out_acc;
  logic [CntW:0] need;

  // hex digit decode
  function automatic logic [HexDigitW:0] hex_value(input logic [7:0] c);
    logic [HexDigitW:0] v;
    v = '0;
    if (c >= 8'h30 && c <= 8'h39) begin
      v = {1'b1, c[HexDigitW-1:0]};
    end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
      v = {1'b1, c[HexDigitW-1:0] + 4'd9};
    end
    return v;
  endfunction

  // handshake
  assign need      = {1'b0, fill_r} + (stg_v_r ? (CntW+1)'(2) : '0);
  assign in_tready = (need <= (CntW+1)'(QDepth - 2));
  assign in_acc    = in_tvalid && in_tready;
  assign out_tvalid = (fill_r != '0);
  assign out_acc   = out_tvalid && out_tready;

  assign out_tdata = queue_r[rd_ptr_r].data;
  assign out_tuser = queue_r[rd_ptr_r].outcome;
  assign out_tlast = queue_r[rd_ptr_r].last;

  // decode one byte
  always_comb begin
    logic [7:0]          c;
    logic                fin;
    logic                do_data;
    logic [7:0]          data_val;
    logic                do_err;
    outcome_t            err_code;
    logic [HexDigitW:0]  hv;
    logic [AccumW-1:0]   accum_upd;
    logic                stopped_upd;
    logic                is_space;

    c           = stg_byte_r;
    fin         = stg_fin_r;
    do_data     = 1'b0;
    data_val    = '0;
    do_err      = 1'b0;
    err_code    = OC_EXPECTED;
    hv          = hex_value(c);
    accum_upd   = (!hex_stopped_r && hv[HexDigitW])
                ? {hex_accum_r[AccumW-HexDigitW-1:0], hv[HexDigitW-1:0]}
                : hex_accum_r;
    stopped_upd = hex_stopped_r || !hv[HexDigitW];
    is_space    = (c == ChSpace) || (c >= ChTab && c <= ChCr);

    mode_nxt        = mode_r;
    hex_count_nxt   = hex_count_r;
    hex_accum_nxt   = hex_accum_r;
    hex_stopped_nxt = hex_stopped_r;
    res0   = '{data: 8'h00, outcome: OC_BYTE, last: 1'b1};
    res1   = '{data: 8'h00, outcome: OC_UNTERM_STR, last: 1'b1};
    push_n = 2'd0;

    if (stg_v_r) begin
      unique case (mode_r)
        MODE_SEEK: begin
          if (is_space) begin
            if (fin) begin
              do_err   = 1'b1;
              err_code = OC_EXPECTED;
            end
          end else if (c == ChQuote) begin
            if (fin) begin
              do_err   = 1'b1;
              err_code = OC_UNTERM_STR;
            end else begin
              mode_nxt = MODE_STR;
            end
          end else begin
            do_err   = 1'b1;
            err_code = OC_EXPECTED;
          end
        end
        MODE_STR: begin
          if (c == ChQuote) begin
            do_err   = 1'b1;
            err_code = OC_CLOSED;
          end else if (c == ChBslash) begin
            if (fin) begin
              do_err   = 1'b1;
              err_code = OC_UNTERM_ESC;
            end else begin
              mode_nxt = MODE_ESC;
            end
          end else begin
            do_data  = 1'b1;
            data_val = c;
          end
        end
        MODE_ESC: begin
          if (c == ChQuote || c == ChBslash) begin
            do_data  = 1'b1;
            data_val = c;
          end else if (c == ChN) begin
            do_data  = 1'b1;
            data_val = ChLf;
          end else if (c == ChR) begin
            do_data  = 1'b1;
            data_val = ChCr;
          end else if (c == ChT) begin
            do_data  = 1'b1;
            data_val = ChTab;
          end else if (c == ChU) begin
            if (fin) begin
              do_err   = 1'b1;
              err_code = OC_TRUNC_UNI;
            end else begin
              mode_nxt        = MODE_HEX;
              hex_count_nxt   = '0;
              hex_accum_nxt   = '0;
              hex_stopped_nxt = 1'b0;
            end
          end else begin
            do_err   = 1'b1;
            err_code = OC_BAD_ESC;
          end
        end
        MODE_HEX: begin
          if (hex_count_r == HexLastIdx) begin
            // fourth byte closes the escape
            hex_count_nxt   = '0;
            hex_accum_nxt   = '0;
            hex_stopped_nxt = 1'b0;
            do_data         = 1'b1;
            data_val        = {1'b0, accum_upd};
          end else if (fin) begin
            do_err   = 1'b1;
            err_code = OC_TRUNC_UNI;
          end else begin
            hex_count_nxt   = hex_count_r + 3'd1;
            hex_accum_nxt   = accum_upd;
            hex_stopped_nxt = stopped_upd;
          end
        end
        default: begin
          mode_nxt = MODE_SEEK;
        end
      endcase

      // emit a decoded byte, plus unterminated string at end of input
      if (do_data) begin
        res0   = '{data: data_val, outcome: OC_BYTE, last: !fin};
        push_n = fin ? 2'd2 : 2'd1;
        mode_nxt = fin ? MODE_SEEK : MODE_STR;
      end

      // any other outcome returns to seeking
      if (do_err) begin
        res0   = '{data: 8'h00, outcome: err_code, last: 1'b1};
        push_n = 2'd1;
      end

      if (do_err || (do_data && fin)) begin
        mode_nxt        = MODE_SEEK;
        hex_count_nxt   = '0;
        hex_accum_nxt   = '0;
        hex_stopped_nxt = 1'b0;
      end
    end
  end

  // queue occupancy
  assign fill_nxt = fill_r + CntW'(push_n) - (out_acc ? CntW'(1) : CntW'(0));

  // control and parser state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_v_r       <= 1'b0;
      mode_r        <= MODE_SEEK;
      hex_count_r   <= '0;
      hex_accum_r   <= '0;
      hex_stopped_r <= 1'b0;
      wr_ptr_r      <= '0;
      rd_ptr_r      <= '0;
      fill_r        <= '0;
    end else begin
      stg_v_r       <= in_acc;
      mode_r        <= mode_nxt;
      hex_count_r   <= hex_count_nxt;
      hex_accum_r   <= hex_accum_nxt;
      hex_stopped_r <= hex_stopped_nxt;
      wr_ptr_r      <= wr_ptr_r + PtrW'(push_n);
      if (out_acc) begin
        rd_ptr_r <= rd_ptr_r + PtrW'(1);
      end
      fill_r <= fill_nxt;
    end
  end

  // input register payload
  always_ff @(posedge clk) begin
    if (in_acc) begin
      stg_byte_r <= in_tdata;
      stg_fin_r  <= in_tlast;
    end
  end

  // result queue writes
  always_ff @(posedge clk) begin
    if (push_n != 2'd0) begin
      queue_r[wr_ptr_r] <= res0;
    end
    if (push_n == 2'd2) begin
      queue_r[wr_ptr_r + PtrW'(1)] <= res1;
    end
  end

  // checks
  `JSU_ASSERT_NOW(a_fill_bound, 1'b1, fill_r <= CntW'(QDepth), "result queue overflow")
  `JSU_ASSERT_NEXT(a_pop_only, out_acc && !stg_v_r, fill_r == $past(fill_r) - CntW'(1), "queue count did not drop on pop")
  `JSU_ASSERT_NEXT(a_err_seek, stg_v_r && push_n == 2'd1 && res0.outcome != OC_BYTE, mode_r == MODE_SEEK, "parser not seeking after an outcome")
  `JSU_ASSERT_NOW(a_hex_mode, hex_count_r != 3'd0, mode_r == MODE_HEX, "hex count live outside a unicode escape")

endmodule

// ===== verif/json_string_unescaper_test.sv =====
// self-checking testbench for the json string unescaper: random text against a decode model
module json_string_unescaper_test;
  import jsu_pkg::*;

  localparam int CYCLE_LIMIT = 600_000;
  localparam int DRAIN_CYCLES = 16;
  localparam int RANDOM_BYTES = 1150;
  localparam int HOLD_AT = 400;
  localparam int HOLD_CYCLES = 150;

  // one input item: a raw byte and the end-of-text flag
  typedef struct packed {
    logic [7:0] b;
    logic       fin;
  } text_byte_t;

  logic       clk;
  logic       rst_n;
  logic       in_tvalid;
  logic       in_tready;
  logic [7:0] in_tdata;
  logic       in_tlast;
  logic       out_tvalid;
  logic       out_tready;
  logic [7:0] out_tdata;
  logic [2:0] out_tuser;
  logic       out_tlast;

  json_string_unescaper i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast)
  );

  text_byte_t text_bytes[$];
  result_t    want_results[$];
  result_t    step_results[$];
  int         bytes_total;
  int         bytes_sent;
  int         errors;
  int         cycles;
  bit         in_took;

  // decoder state
  mode_t      pm;
  logic [2:0] hcnt;
  logic [6:0] hacc;
  logic       hstop;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // ---------------------------------------------------------------- decoder

  function automatic bit is_ws(logic [7:0] c);
    return c == ChSpace || (c >= ChTab && c <= ChCr);
  endfunction

  function automatic int hex_val(logic [7:0] c);
    if (c >= "0" && c <= "9") return int'(c) - int'("0");
    if (c >= "a" && c <= "f") return int'(c) - int'("a") + 10;
    if (c >= "A" && c <= "F") return int'(c) - int'("A") + 10;
    return -1;
  endfunction

  task automatic emit(logic [7:0] d, outcome_t oc);
    result_t r;
    r.data = d;
    r.outcome = oc;
    r.last = 1'b0;
    step_results.insert(step_results.size(), r);
  endtask

  task automatic to_seek();
    pm = MODE_SEEK;
    hcnt = '0;
    hacc = '0;
    hstop = 1'b0;
  endtask

  // decoded byte; at end of text the string is left open
  task automatic put_data(logic [7:0] v, logic fin);
    emit(v, OC_BYTE);
    pm = MODE_STR;
    if (fin) begin
      emit(8'h00, OC_UNTERM_STR);
      to_seek();
    end
  endtask

  task automatic decode_byte(logic [7:0] c, logic fin);
    int d;
    logic [31:0] t;
    step_results.delete();
    case (pm)
      MODE_SEEK: begin
        if (is_ws(c)) begin
          if (fin) begin
            emit(8'h00, OC_EXPECTED);
            to_seek();
          end
        end else if (c == ChQuote) begin
          if (fin) begin
            emit(8'h00, OC_UNTERM_STR);
            to_seek();
          end else begin
            pm = MODE_STR;
          end
        end else begin
          emit(8'h00, OC_EXPECTED);
          to_seek();
        end
      end
      MODE_STR: begin
        if (c == ChQuote) begin
          emit(8'h00, OC_CLOSED);
          to_seek();
        end else if (c == ChBslash) begin
          if (fin) begin
            emit(8'h00, OC_UNTERM_ESC);
            to_seek();
          end else begin
            pm = MODE_ESC;
          end
        end else begin
          put_data(c, fin);
        end
      end
      MODE_ESC: begin
        if (c == ChQuote || c == ChBslash) put_data(c, fin);
        else if (c == ChN) put_data(ChLf, fin);
        else if (c == ChR) put_data(ChCr, fin);
        else if (c == ChT) put_data(ChTab, fin);
        else if (c == ChU) begin
          if (fin) begin
            emit(8'h00, OC_TRUNC_UNI);
            to_seek();
          end else begin
            pm = MODE_HEX;
            hcnt = '0;
            hacc = '0;
            hstop = 1'b0;
          end
        end else begin
          emit(8'h00, OC_BAD_ESC);
          to_seek();
        end
      end
      default: begin
        // hex digits accumulate until the first non-hex byte
        d = hex_val(c);
        if (!hstop && d >= 0) begin
          t = 32'(hacc) * 16 + 32'(d);
          hacc = t[6:0];
        end else begin
          hstop = 1'b1;
        end
        hcnt = hcnt + 3'd1;
        if (hcnt >= 3'd4) begin
          t = 32'(hacc);
          hcnt = '0;
          hacc = '0;
          hstop = 1'b0;
          put_data({1'b0, t[6:0]}, fin);
        end else if (fin) begin
          emit(8'h00, OC_TRUNC_UNI);
          to_seek();
        end
      end
    endcase
    if (step_results.size() > 0) step_results[step_results.size() - 1].last = 1'b1;
    foreach (step_results[i]) want_results.insert(want_results.size(), step_results[i]);
  endtask

  // ---------------------------------------------------------------- stimulus

  task automatic add_byte(logic [7:0] b, logic fin);
    text_byte_t t;
    t.b = b;
    t.fin = fin;
    text_bytes.insert(text_bytes.size(), t);
  endtask

  task automatic add_text(string s);
    for (int i = 0; i < s.len(); i++) add_byte(s[i], 1'b0);
  endtask

  function automatic logic [7:0] hex_char();
    string digits;
    digits = "0123456789abcdefABCDEF";
    return digits[$urandom_range(0, 21)];
  endfunction

  // bytes that mostly stop hex reading; the default choice is any random byte
  function automatic logic [7:0] odd_char();
    case ($urandom_range(0, 6))
      0: return "+";
      1: return "-";
      2: return ChSpace;
      3: return "x";
      4: return ChQuote;
      5: return ChBslash;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic logic [7:0] plain_char();
    logic [7:0] c;
    c = 8'($urandom_range(0, 255));
    while (c == ChQuote || c == ChBslash) c = 8'($urandom_range(0, 255));
    return c;
  endfunction

  // one string literal with random content; a broken one ends early at end of text
  task automatic add_string(bit broken);
    logic [7:0] txt[$];
    logic [7:0] ws_set[6];
    int n;
    int cut;
    ws_set = '{ChSpace, ChTab, ChLf, 8'h0b, 8'h0c, ChCr};
    repeat ($urandom_range(0, 2)) txt.insert(txt.size(), ws_set[$urandom_range(0, 5)]);
    txt.insert(txt.size(), ChQuote);
    n = $urandom_range(0, 10);
    repeat (n) begin
      case ($urandom_range(0, 7))
        0, 1, 2, 3: txt.insert(txt.size(), plain_char());
        4, 5: begin
          txt.insert(txt.size(), ChBslash);
          case ($urandom_range(0, 9))
            0: txt.insert(txt.size(), ChQuote);
            1: txt.insert(txt.size(), ChBslash);
            2, 3: txt.insert(txt.size(), ChN);
            4: txt.insert(txt.size(), ChR);
            5, 6: txt.insert(txt.size(), ChT);
            7, 8: txt.insert(txt.size(), 8'($urandom_range("a", "z")));
            default: txt.insert(txt.size(), 8'($urandom_range(0, 255)));
          endcase
        end
        default: begin
          txt.insert(txt.size(), ChBslash);
          txt.insert(txt.size(), ChU);
          repeat (4)
            txt.insert(txt.size(), $urandom_range(0, 6) == 0 ? odd_char() : hex_char());
        end
      endcase
    end
    txt.insert(txt.size(), ChQuote);
    if (broken) begin
      cut = $urandom_range(1, txt.size() - 1);
      for (int i = 0; i < cut; i++) add_byte(txt[i], i == cut - 1);
    end else begin
      for (int i = 0; i < txt.size(); i++)
        add_byte(txt[i], i == txt.size() - 1 && $urandom_range(0, 7) == 0);
    end
  endtask

  task automatic add_directed();
    add_byte(8'hff, 1'b0);                 // wrong opening byte
    add_byte(ChCr, 1'b1);                  // text ends while seeking
    add_byte(ChQuote, 1'b1);               // quote as the last byte
    add_byte(ChSpace, 1'b0);
    add_byte(ChQuote, 1'b0);
    add_text("\\n\\r\\t\\\\\\\"");         // every simple escape
    add_text("\\u7F 0");                   // space stops hex reading
    add_text("\\u0x\"+");                  // 0x prefix, quote inside the digits
    add_byte(8'h80, 1'b0);
    add_byte(ChQuote, 1'b0);
    add_byte(ChQuote, 1'b0);
    add_byte(8'h00, 1'b1);                 // decoded byte as the last byte
    add_byte(ChQuote, 1'b0);
    add_byte(ChBslash, 1'b1);              // backslash as the last byte
    add_text("\"\\q");                     // unknown escape letter
    add_text("\"\\u");
    add_byte("A", 1'b1);                   // unicode cut short
  endtask

  task automatic add_random();
    int stop_at;
    stop_at = text_bytes.size() + RANDOM_BYTES;
    while (text_bytes.size() < stop_at) begin
      case ($urandom_range(0, 19))
        0, 1, 2: add_string(1'b1);
        3, 4: begin
          repeat ($urandom_range(1, 6))
            add_byte(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
        end
        5: add_byte(ChU, 1'b1);
        default: add_string(1'b0);
      endcase
    end
  endtask

  // ---------------------------------------------------------------- idling

  function automatic int pick_gap(bit calm);
    int p;
    if (calm) return 0;
    p = $urandom_range(0, 99);
    if (p < 60) return 0;
    if (p < 90) return $urandom_range(1, 3);
    if (p < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 40);
  endfunction

  // ---------------------------------------------------------------- driver

  int in_gap;
  bit in_calm;

  // input channel, changes at the falling edge
  always @(negedge clk) begin
    text_byte_t t;
    if (rst_n) begin
      if (!in_tvalid || in_took) begin
        if (in_gap > 0) begin
          in_tvalid <= 1'b0;
          in_gap = in_gap - 1;
        end else if (text_bytes.size() > 0) begin
          t = text_bytes.pop_front();
          in_tdata <= t.b;
          in_tlast <= t.fin;
          in_tvalid <= 1'b1;
          if ($urandom_range(0, 79) == 0) in_calm = !in_calm;
          in_gap = pick_gap(in_calm);
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------- receiver

  int  out_gap;
  int  hold_left;
  bit  hold_done;
  bit  out_calm;

  // result channel ready, with one long hold-off once the text is flowing
  always @(negedge clk) begin
    if (rst_n) begin
      if (!hold_done && bytes_sent >= HOLD_AT) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        out_tready <= 1'b0;
        hold_left = hold_left - 1;
      end else if (out_gap > 0) begin
        out_tready <= 1'b0;
        out_gap = out_gap - 1;
      end else begin
        out_tready <= 1'b1;
        if ($urandom_range(0, 79) == 0) out_calm = !out_calm;
        out_gap = pick_gap(out_calm);
      end
    end
  end

  // ---------------------------------------------------------------- monitor

  task automatic report(string what);
    $display("%0t: %s", $time, what);
    errors = errors + 1;
  endtask

  // takes items at the rising edge, predicts and checks
  always @(posedge clk) begin
    result_t r;
    in_took = 1'b0;
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        in_took = 1'b1;
        decode_byte(in_tdata, in_tlast);
        bytes_sent = bytes_sent + 1;
      end
      if (out_tvalid && out_tready) begin
        if (want_results.size() == 0) begin
          report($sformatf("unexpected result byte %02h outcome %0d last %0b",
                           out_tdata, out_tuser, out_tlast));
        end else begin
          r = want_results.pop_front();
          if (out_tdata !== r.data)
            report($sformatf("byte %02h, want %02h", out_tdata, r.data));
          if (out_tuser !== r.outcome)
            report($sformatf("outcome %0d, want %0d", out_tuser, r.outcome));
          if (out_tlast !== r.last)
            report($sformatf("last %0b, want %0b", out_tlast, r.last));
        end
      end
    end
  end

  // ---------------------------------------------------------------- timeout

  always @(posedge clk) begin
    cycles = cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("json_string_unescaper: mismatch");
      $finish;
    end
  end

  // ---------------------------------------------------------------- sequence

  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tlast = 1'b0;
    out_tready = 1'b0;
    bytes_sent = 0;
    errors = 0;
    cycles = 0;
    in_gap = 0;
    out_gap = 0;
    hold_left = 0;
    hold_done = 1'b0;
    in_calm = 1'b0;
    out_calm = 1'b0;
    in_took = 1'b0;
    to_seek();
    add_directed();
    add_random();
    bytes_total = text_bytes.size();
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    // wait for all text to be taken and all results to arrive
    while (bytes_sent < bytes_total) @(posedge clk);
    while (want_results.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("json_string_unescaper: match");
    end else begin
      $display("json_string_unescaper: mismatch");
    end
    $finish;
  end

endmodule
